// ===== rtl/ttm_pkg.sv =====
`default_nettype none
package ttm_pkg;

	localparam int COORD_BITS = 12;
	localparam int TEX_BITS   = 10;
	localparam int FRAC_BITS  = 16;
	localparam int EDGE_W     = 32;
	localparam int SLOPE_W    = 24;
	localparam int CANVAS_W   = 12;
	localparam int TSZ_W      = TEX_BITS + 1;
	localparam int SPAN_W     = COORD_BITS + 1;
	localparam int REL_W      = ((SPAN_W + FRAC_BITS > EDGE_W) ? SPAN_W + FRAC_BITS : EDGE_W) + 1;
	localparam int P_W        = REL_W + TSZ_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VSLOPE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HSLOPE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H    = 3'd4;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic                         command;
		logic signed [COORD_BITS-1:0] front_x;
		logic signed [COORD_BITS-1:0] front_y;
		logic [COORD_BITS-2:0]        front_w;
		logic [COORD_BITS-2:0]        front_h;
		logic signed [COORD_BITS-1:0] back_pos;
		logic [TSZ_W-1:0]             texture_width;
		logic [TSZ_W-1:0]             texture_height;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] dest_x;
		logic signed [COORD_BITS-1:0] dest_y;
		logic [TEX_BITS-1:0]          texel_x;
		logic [TEX_BITS-1:0]          texel_y;
		logic                         write_pixel;
		logic                         done_res;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/trapezoid_texture_mapper.sv =====
`default_nettype none
// Trapezoid texture address generator. A start beat latches the front rectangle, the far
// line and the texture size and returns nothing; each step beat returns one pixel with its
// texel, or a beat with done_res set once the shape is finished. A step first skips empty
// lines one by one, then makes two passes through a shared bit-serial ratio unit (multiply by
// texture size one bit per cycle, then one quotient bit per cycle); a pass is shorter when its
// ratio clamps before its quotient pass. A finished result waits in an output register.
module trapezoid_texture_mapper import ttm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SLOPE_W-1:0]   cfg_data
);

	localparam int QW   = EDGE_W - FRAC_BITS;
	localparam int CLW  = ((QW > COORD_BITS) ? QW : COORD_BITS) + 1;
	localparam int CMPW = ((COORD_BITS > CANVAS_W) ? COORD_BITS : CANVAS_W) + 1;
	localparam logic signed [CLW-1:0] CMIN_E = CLW'(-(2 ** (COORD_BITS - 1)));
	localparam logic signed [CLW-1:0] CMAX_E = CLW'((2 ** (COORD_BITS - 1)) - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LINE = 3'd2;
	localparam logic [2:0] ST_SPAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	function automatic logic signed [COORD_BITS-1:0] clampc(input logic signed [QW-1:0] v);
		logic signed [CLW-1:0] e;
		e = CLW'(v);
		if (e < CMIN_E) clampc = CMIN_E[COORD_BITS-1:0];
		else if (e > CMAX_E) clampc = CMAX_E[COORD_BITS-1:0];
		else clampc = e[COORD_BITS-1:0];
	endfunction

	function automatic logic signed [COORD_BITS-1:0] q_trunc(input logic signed [EDGE_W-1:0] v);
		logic signed [QW-1:0] s;
		s = v[EDGE_W-1:FRAC_BITS];
		if (v[EDGE_W-1] && (|v[FRAC_BITS-1:0])) s = s + QW'(1);
		q_trunc = clampc(s);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] q_floor(input logic signed [EDGE_W-1:0] v);
		logic signed [QW-1:0] s;
		s = v[EDGE_W-1:FRAC_BITS];
		q_floor = clampc(s);
	endfunction

	logic                        orient_q;
	logic signed [SLOPE_W-1:0]   vslope_q, hslope_q;
	logic [CANVAS_W-1:0]         cw_q, ch_q;

	logic [2:0]                  state_q;
	logic                        busy_q, mode_q, line_dir_q;
	logic signed [COORD_BITS-1:0] line_pos_q, line_org_q, line_end_q;
	logic [COORD_BITS-1:0]       line_cnt_q;
	logic signed [SPAN_W-1:0]    span_pos_q;
	logic signed [EDGE_W-1:0]    near_q, far_q;
	logic [TSZ_W-1:0]            texw_q, texh_q;
	logic [TEX_BITS-1:0]         tline_q;
	out_item_t                   res_q, out_q;
	logic                        out_valid_q;

	logic                         in_acc, cfg_acc, out_free;
	logic signed [COORD_BITS-1:0] st_org, st_lo, st_bp;
	logic [COORD_BITS-2:0]        st_sz;
	logic signed [COORD_BITS:0]   st_hi, st_diff;
	logic                         st_dir;
	logic signed [EDGE_W-1:0]     st_near, st_far, slope_e, near_adv, far_adv;
	logic signed [SPAN_W-1:0]     far_fl;
	logic                         skip, finish;
	logic signed [COORD_BITS:0]   l_rel;
	logic [COORD_BITS:0]          l_abs;
	logic signed [REL_W-1:0]      s_rel, s_den;
	logic [REL_W-1:0]             rat_num, rat_den;
	logic [TSZ_W-1:0]             rat_tex;
	logic                         rat_start, rat_done;
	logic [TEX_BITS-1:0]          rat_q;
	logic signed [COORD_BITS-1:0] px_x, px_y;
	logic                         px_on;
	out_item_t                    px_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		st_org  = orient_q ? in_data.front_y : in_data.front_x;
		st_lo   = orient_q ? in_data.front_x : in_data.front_y;
		st_sz   = orient_q ? in_data.front_w : in_data.front_h;
		st_bp   = in_data.back_pos;
		st_dir  = st_org > st_bp;
		st_diff = st_dir ? ((COORD_BITS+1)'(st_org) - (COORD_BITS+1)'(st_bp))
		                 : ((COORD_BITS+1)'(st_bp) - (COORD_BITS+1)'(st_org));
		st_hi   = (COORD_BITS+1)'(st_lo) + (COORD_BITS+1)'(st_sz);
		st_near = EDGE_W'(st_lo) << FRAC_BITS;
		st_far  = EDGE_W'(st_hi) << FRAC_BITS;

		slope_e  = mode_q ? EDGE_W'(hslope_q) : EDGE_W'(vslope_q);
		near_adv = near_q + slope_e;
		far_adv  = far_q - slope_e;
		far_fl   = SPAN_W'(q_floor(far_q));
		skip     = busy_q && (line_pos_q != line_end_q) && (span_pos_q > far_fl);
		finish   = !busy_q || (line_pos_q == line_end_q);

		l_rel = (COORD_BITS+1)'(line_pos_q) - (COORD_BITS+1)'(line_org_q);
		l_abs = l_rel[COORD_BITS] ? -l_rel : l_rel;
		s_rel = (REL_W'(span_pos_q) << FRAC_BITS) - REL_W'(near_q);
		s_den = REL_W'(far_q) - REL_W'(near_q);

		if (state_q == ST_SCAN) begin
			rat_num = REL_W'(l_abs);
			rat_den = REL_W'(line_cnt_q);
			rat_tex = mode_q ? texh_q : texw_q;
		end else begin
			rat_num = s_rel[REL_W-1] ? -s_rel : s_rel;
			rat_den = (s_den > 0) ? s_den : '0;
			rat_tex = mode_q ? texw_q : texh_q;
		end
		rat_start = ((state_q == ST_SCAN) && !skip && !finish)
		         || ((state_q == ST_LINE) && rat_done);

		px_x  = mode_q ? span_pos_q[COORD_BITS-1:0] : line_pos_q;
		px_y  = mode_q ? line_pos_q : span_pos_q[COORD_BITS-1:0];
		px_on = !px_x[COORD_BITS-1] && !px_y[COORD_BITS-1]
		     && (CMPW'(unsigned'(px_x)) < CMPW'(cw_q))
		     && (CMPW'(unsigned'(px_y)) < CMPW'(ch_q));
		px_res.dest_x      = px_x;
		px_res.dest_y      = px_y;
		px_res.texel_x     = mode_q ? rat_q : tline_q;
		px_res.texel_y     = mode_q ? tline_q : rat_q;
		px_res.write_pixel = px_on;
		px_res.done_res    = 1'b0;
	end

	ttm_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rat_start),
		.num    (rat_num),
		.den    (rat_den),
		.tex    (rat_tex),
		.done   (rat_done),
		.q      (rat_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q    <= 1'b0;
			vslope_q    <= '0;
			hslope_q    <= '0;
			cw_q        <= CANVAS_W'(640);
			ch_q        <= CANVAS_W'(480);
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					REG_ORIENTATION: orient_q <= cfg_data[0];
					REG_VSLOPE:      vslope_q <= cfg_data;
					REG_HSLOPE:      hslope_q <= cfg_data;
					REG_CANVAS_W:    cw_q     <= cfg_data[CANVAS_W-1:0];
					REG_CANVAS_H:    ch_q     <= cfg_data[CANVAS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != ST_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.command == CMD_START) begin
							busy_q <= 1'b1;
							mode_q <= orient_q;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!skip) begin
						if (finish) begin
							busy_q  <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_LINE;
						end
					end
				end
				ST_LINE: begin
					if (rat_done) state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					if (rat_done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_data.command == CMD_START) begin
					line_org_q <= st_org;
					line_pos_q <= st_org;
					line_end_q <= st_bp;
					line_dir_q <= st_dir;
					line_cnt_q <= st_diff[COORD_BITS-1:0];
					near_q     <= st_near;
					far_q      <= st_far;
					span_pos_q <= SPAN_W'(q_trunc(st_near));
					texw_q     <= in_data.texture_width;
					texh_q     <= in_data.texture_height;
				end
			end
			ST_SCAN: begin
				if (skip) begin
					line_pos_q <= line_dir_q ? line_pos_q - COORD_BITS'(1)
					                         : line_pos_q + COORD_BITS'(1);
					near_q     <= near_adv;
					far_q      <= far_adv;
					span_pos_q <= SPAN_W'(q_trunc(near_adv));
				end else if (finish) begin
					res_q <= '{dest_x: '0, dest_y: '0, texel_x: '0, texel_y: '0,
					           write_pixel: 1'b0, done_res: 1'b1};
				end
			end
			ST_LINE: begin
				if (rat_done) tline_q <= rat_q;
			end
			ST_SPAN: begin
				if (rat_done) begin
					res_q      <= px_res;
					span_pos_q <= span_pos_q + SPAN_W'(1);
				end
			end
			ST_EMIT: begin
				if (out_free) out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_done_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.texel_x == '0 && out_data.texel_y == '0
			&& !out_data.write_pixel)
		else $error("done beat carries pixel data");

	a_write_on_canvas: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_pixel |-> !out_data.dest_x[COORD_BITS-1]
			&& !out_data.dest_y[COORD_BITS-1])
		else $error("pixel written at negative position");

	a_ratio_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rat_done |-> state_q == ST_LINE || state_q == ST_SPAN)
		else $error("ratio result outside a ratio pass");

endmodule
`default_nettype wire

// ===== rtl/ttm_ratio.sv =====
`default_nettype none
module ttm_ratio import ttm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [REL_W-1:0]   num,
	input  wire logic [REL_W-1:0]   den,
	input  wire logic [TSZ_W-1:0]   tex,
	output logic                    done,
	output logic [TEX_BITS-1:0]     q
);

	localparam int CNT_W = $clog2(TSZ_W + 1);
	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_MUL  = 2'd1;
	localparam logic [1:0] R_CHK  = 2'd2;
	localparam logic [1:0] R_DIV  = 2'd3;

	logic [1:0]       ph_q;
	logic [CNT_W-1:0] cnt_q;
	logic [P_W-1:0]   acc_q, dsh_q;
	logic [REL_W-1:0] num_q, den_q;
	logic [TSZ_W-1:0] tex_q, mpl_q, quo_q;
	logic             done_q;
	logic [TEX_BITS-1:0] q_q;

	logic [P_W-1:0]   limit, acc_add;
	logic             ge;
	logic [TSZ_W-1:0] qfull, tmax;

	always_comb begin
		limit   = P_W'(den_q) << TSZ_W;
		acc_add = (acc_q << 1) + (mpl_q[TSZ_W-1] ? P_W'(num_q) : '0);
		ge      = acc_q >= dsh_q;
		qfull   = {quo_q[TSZ_W-2:0], ge};
		tmax    = tex_q - TSZ_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= R_IDLE;
			done_q <= 1'b0;
		end else begin
			case (ph_q)
				R_IDLE: begin
					done_q <= 1'b0;
					if (start) ph_q <= R_MUL;
				end
				R_MUL: begin
					done_q <= 1'b0;
					if (cnt_q == CNT_W'(1)) ph_q <= R_CHK;
				end
				R_CHK: begin
					if (den_q == '0 || tex_q == '0 || acc_q >= limit) begin
						ph_q   <= R_IDLE;
						done_q <= 1'b1;
					end else begin
						ph_q   <= R_DIV;
						done_q <= 1'b0;
					end
				end
				R_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						ph_q   <= R_IDLE;
						done_q <= 1'b1;
					end else begin
						done_q <= 1'b0;
					end
				end
				default: begin
					ph_q   <= R_IDLE;
					done_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			R_IDLE: begin
				num_q <= num;
				den_q <= den;
				tex_q <= tex;
				mpl_q <= tex;
				acc_q <= '0;
				cnt_q <= CNT_W'(TSZ_W);
			end
			R_MUL: begin
				acc_q <= acc_add;
				mpl_q <= mpl_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			R_CHK: begin
				dsh_q <= P_W'(den_q) << (TSZ_W - 1);
				cnt_q <= CNT_W'(TSZ_W);
				quo_q <= '0;
				if (den_q == '0 || tex_q == '0) q_q <= '0;
				else q_q <= tmax[TEX_BITS-1:0];
			end
			R_DIV: begin
				if (ge) acc_q <= acc_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				quo_q <= qfull;
				cnt_q <= cnt_q - CNT_W'(1);
				q_q   <= (qfull > tmax) ? tmax[TEX_BITS-1:0] : qfull[TEX_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire

// ===== bench/trapezoid_texture_mapper_tb.sv =====
`default_nettype none
module trapezoid_texture_mapper_tb;
	import ttm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CMIN = -(64'sd1 <<< (COORD_BITS - 1));
	localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint TIMEOUT_CYCLES = 4000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SLOPE_W-1:0]   cfg_data = '0;

	trapezoid_texture_mapper u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mapper model state
	logic                   m_orient;
	logic [SLOPE_W-1:0]     m_vslope, m_hslope;
	logic [CANVAS_W-1:0]    m_cw, m_ch;
	bit                     m_busy, m_floor, m_dir;
	longint                 m_lpos, m_lorg, m_lend, m_lcnt, m_spos;
	int                     m_near, m_far;
	logic [TSZ_W-1:0]       m_tw, m_th;

	out_item_t pixel_q[$];
	int        errors = 0;
	bit        quiet = 1'b0;
	longint    cycles = 0;

	function automatic longint clampc(longint v);
		return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
	endfunction

	function automatic longint q_trunc(int v);
		longint w;
		w = v;
		return (w >= 0) ? (w >>> FRAC_BITS) : -((-w) >>> FRAC_BITS);
	endfunction

	function automatic longint q_floor(int v);
		longint w;
		w = v;
		return (w >= 0) ? (w >>> FRAC_BITS) : -(((-w) + (64'sd1 <<< FRAC_BITS) - 1) >>> FRAC_BITS);
	endfunction

	function automatic longint unsigned tex_ratio(longint unsigned num, longint unsigned den,
			longint unsigned tex);
		longint unsigned q;
		if (den == 0 || tex == 0)
			return 0;
		q = num * tex / den;
		if (q > tex - 1)
			q = tex - 1;
		return q & ((64'd1 << TEX_BITS) - 1);
	endfunction

	function automatic void next_line();
		longint s;
		s = m_floor ? longint'($signed(m_hslope)) : longint'($signed(m_vslope));
		m_lpos += m_dir ? -1 : 1;
		m_near = int'(longint'(m_near) + s);
		m_far = int'(longint'(m_far) - s);
		m_spos = clampc(q_trunc(m_near));
	endfunction

	function automatic bit map_pixel(in_item_t it, output out_item_t r);
		longint org, lo, sz, rel, lim, x, y;
		longint unsigned tl, ts, t_line, t_span, num, den;
		r = '0;
		if (it.command == CMD_START) begin
			org = m_orient ? it.front_y : it.front_x;
			lo = m_orient ? it.front_x : it.front_y;
			sz = m_orient ? longint'(it.front_w) : longint'(it.front_h);
			m_floor = m_orient;
			m_tw = it.texture_width;
			m_th = it.texture_height;
			m_lorg = org;
			m_lpos = org;
			m_lend = it.back_pos;
			m_dir = org > m_lend;
			m_lcnt = m_dir ? org - m_lend : m_lend - org;
			m_near = int'(lo * (64'sd1 <<< FRAC_BITS));
			m_far = int'((lo + sz) * (64'sd1 <<< FRAC_BITS));
			m_spos = clampc(q_trunc(m_near));
			m_busy = 1'b1;
			return 1'b0;
		end
		while (m_busy && m_lpos != m_lend && m_spos > clampc(q_floor(m_far)))
			next_line();
		if (!m_busy || m_lpos == m_lend) begin
			m_busy = 1'b0;
			r.done_res = 1'b1;
			return 1'b1;
		end
		tl = m_floor ? m_th : m_tw;
		ts = m_floor ? m_tw : m_th;
		rel = m_lpos - m_lorg;
		t_line = tex_ratio(rel < 0 ? -rel : rel, m_lcnt, tl);
		rel = m_spos * (64'sd1 <<< FRAC_BITS) - longint'(m_near);
		num = rel < 0 ? -rel : rel;
		lim = longint'(m_far) - longint'(m_near);
		den = lim > 0 ? lim : 0;
		t_span = tex_ratio(num, den, ts);
		x = m_floor ? m_spos : m_lpos;
		y = m_floor ? m_lpos : m_spos;
		r.dest_x = x[COORD_BITS-1:0];
		r.dest_y = y[COORD_BITS-1:0];
		r.texel_x = m_floor ? t_span[TEX_BITS-1:0] : t_line[TEX_BITS-1:0];
		r.texel_y = m_floor ? t_line[TEX_BITS-1:0] : t_span[TEX_BITS-1:0];
		r.write_pixel = x >= 0 && x < longint'(m_cw) && y >= 0 && y < longint'(m_ch);
		r.done_res = 1'b0;
		m_spos++;
		return 1'b1;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	always @(posedge clk) begin
		out_item_t e;
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
		out_ready <= quiet || ($urandom_range(99) >= 9);
		if (out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				e = pixel_q.pop_front();
				if (out_data.dest_x !== e.dest_x) report("dest_x", out_data.dest_x, e.dest_x);
				if (out_data.dest_y !== e.dest_y) report("dest_y", out_data.dest_y, e.dest_y);
				if (out_data.texel_x !== e.texel_x) report("texel_x", out_data.texel_x, e.texel_x);
				if (out_data.texel_y !== e.texel_y) report("texel_y", out_data.texel_y, e.texel_y);
				if (out_data.write_pixel !== e.write_pixel)
					report("write_pixel", out_data.write_pixel, e.write_pixel);
				if (out_data.done_res !== e.done_res)
					report("done_res", out_data.done_res, e.done_res);
			end
		end
	end

	task automatic send(in_item_t it, bit typed, out_item_t want);
		out_item_t r;
		bit has;
		if (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		has = map_pixel(it, r);
		if (has)
			pixel_q.push_back(typed ? want : r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SLOPE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIENTATION: m_orient = val[0];
			REG_VSLOPE:      m_vslope = val;
			REG_HSLOPE:      m_hslope = val;
			REG_CANVAS_W:    m_cw = val[CANVAS_W-1:0];
			REG_CANVAS_H:    m_ch = val[CANVAS_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t mk(logic cmd, int fx, int fy, int fw, int fh, int bp,
			int tw, int th);
		in_item_t it;
		it.command = cmd;
		it.front_x = fx;
		it.front_y = fy;
		it.front_w = fw;
		it.front_h = fh;
		it.back_pos = bp;
		it.texture_width = tw;
		it.texture_height = th;
		return it;
	endfunction

	function automatic logic [SLOPE_W-1:0] pick_slope();
		case ($urandom_range(5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h0;
			3: return $urandom;
			default: return 24'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
		endcase
	endfunction

	function automatic logic [CANVAS_W-1:0] pick_canvas();
		case ($urandom_range(4))
			0: return 12'd1;
			1: return 12'h800;
			default: return 12'($urandom_range(1, 2048));
		endcase
	endfunction

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} row_t;

	initial begin
		row_t      rows[$];
		out_item_t none, done_beat, px0;
		in_item_t  it;
		int        count, org, steps, tw, th;
		m_orient = 0; m_vslope = 0; m_hslope = 0; m_cw = 640; m_ch = 480;
		m_busy = 0; m_floor = 0; m_dir = 0;
		m_lpos = 0; m_lorg = 0; m_lend = 0; m_lcnt = 0; m_spos = 0;
		m_near = 0; m_far = 0; m_tw = 0; m_th = 0;
		none = '0;
		done_beat = '0;
		done_beat.done_res = 1'b1;
		px0 = '0;
		px0.write_pixel = 1'b1;

		rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, done_beat});
		rows.push_back('{mk(CMD_START, 0, 0, 0, 0, 1, 1, 1), 0, none});
		rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, px0});
		rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, done_beat});
		rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, done_beat});
		rows.push_back('{mk(CMD_START, 5, 9, 3, 3, 5, 8, 8), 0, none});
		rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, done_beat});
		rows.push_back('{mk(CMD_START, -2048, -2048, 2047, 2047, 2047, 2047, 2047), 0, none});
		repeat (3) rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 0, none});
		rows.push_back('{mk(CMD_START, 2047, 100, 0, 10, -2048, 0, 0), 0, none});
		repeat (2) rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 0, none});
		rows.push_back('{mk(CMD_START, 10, 2047, 5, 2047, 12, 1024, 1024), 0, none});
		repeat (2) rows.push_back('{mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 0, none});
		rows.push_back('{mk(CMD_START, 638, 478, 1, 3, 642, 7, 3), 0, none});
		repeat (4) rows.push_back('{mk(CMD_STEP, -1, -1, 2047, 2047, -1, 2047, 2047), 0, none});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].it, rows[i].typed, rows[i].want);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_ORIENTATION, p % 2);
			write_reg(REG_VSLOPE, p == 0 ? 24'h0 : pick_slope());
			write_reg(REG_HSLOPE, p == 1 ? 24'h0 : pick_slope());
			write_reg(REG_CANVAS_W, p == 2 ? 12'd1 : (p == 3 ? 12'h800 : pick_canvas()));
			write_reg(REG_CANVAS_H, p == 2 ? 12'h800 : (p == 3 ? 12'd1 : pick_canvas()));
			quiet = (p == 3);
			count = 0;
			while (count < 280) begin
				if ($urandom_range(9) == 0) begin
					it = $urandom;
					it.front_x = $urandom;
					it.front_y = $urandom;
					it.back_pos = $urandom;
					it.texture_width = $urandom;
					it.texture_height = $urandom;
					send(it, 0, none);
					count++;
				end else begin
					tw = $urandom_range(9) == 0 ? ($urandom_range(1) ? 0 : 2047)
						: $urandom_range(1, 1024);
					th = $urandom_range(9) == 0 ? ($urandom_range(1) ? 2047 : 0)
						: $urandom_range(1, 1024);
					it = mk(CMD_START, $urandom_range(0, 750) - 50, $urandom_range(0, 550) - 50,
						$urandom_range(0, 40), $urandom_range(0, 40), 0, tw, th);
					org = m_orient ? it.front_y : it.front_x;
					it.back_pos = org + ($urandom_range(0, 40) - 20);
					send(it, 0, none);
					steps = $urandom_range(1, 40);
					for (int s = 0; s < steps; s++) begin
						it = $urandom;
						it.command = CMD_STEP;
						send(it, 0, none);
					end
					count += steps + 1;
				end
			end
			drain();
		end
		quiet = 1'b0;

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
